// ===== rtl/ulenc_pkg.sv =====
// ----------------------------------------------------------------------------
// ulenc_pkg
// Shared constants and the character mapping of the line encoder.
// ----------------------------------------------------------------------------
package ulenc_pkg;

  localparam int unsigned LINE_BYTES_DEF = 45;
  localparam int unsigned BYTE_W         = 8;
  localparam int unsigned ZSYM_W         = 7;
  localparam int unsigned SIX_W          = 6;
  localparam int unsigned GROUP_W        = 3 * BYTE_W;

  localparam logic [ZSYM_W-1:0] ZERO_SYM_RESET = 7'd96;  // backquote
  localparam logic [BYTE_W-1:0] CHAR_OFFSET    = 8'd32;
  localparam logic [BYTE_W-1:0] NEWLINE_CHAR   = 8'h0A;

  // six-bit value to printable character; zero takes the programmable symbol
  function automatic logic [BYTE_W-1:0] map_six(input logic [SIX_W-1:0] v,
                                                input logic [ZSYM_W-1:0] zsym);
    logic [BYTE_W-1:0] c;
    if (v == '0) begin
      c = {1'b0, zsym};
    end else begin
      c = {2'b00, v} + CHAR_OFFSET;
    end
    return c;
  endfunction

endpackage

// ===== rtl/ulenc_in_if.sv =====
// ----------------------------------------------------------------------------
// ulenc_in_if
// Source byte channel: one raw byte and an end-of-data mark per transfer.
// ----------------------------------------------------------------------------
interface ulenc_in_if;
  import ulenc_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              end_of_data;

  modport source (output valid, output data_byte, output end_of_data, input ready);
  modport sink   (input valid, input data_byte, input end_of_data, output ready);
endinterface

// ===== rtl/ulenc_out_if.sv =====
// ----------------------------------------------------------------------------
// ulenc_out_if
// Encoded character channel: one character and a burst-end flag per transfer.
// ----------------------------------------------------------------------------
interface ulenc_out_if;
  import ulenc_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_char;
  logic              run_last;

  modport source (output valid, output out_char, output run_last, input ready);
  modport sink   (input valid, input out_char, input run_last, output ready);
endinterface

// ===== rtl/ulenc_store.sv =====
// ----------------------------------------------------------------------------
// ulenc_store
// Line buffer: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ulenc_store #(
  parameter int unsigned LINE_BYTES = ulenc_pkg::LINE_BYTES_DEF,
  parameter int unsigned AW         = $clog2(LINE_BYTES)
) (
  input  logic                           clk_i,
  input  logic                           we_i,
  input  logic [AW-1:0]                  waddr_i,
  input  logic [ulenc_pkg::BYTE_W-1:0]   wdata_i,
  input  logic                           re_i,
  input  logic [AW-1:0]                  raddr_i,
  output logic [ulenc_pkg::BYTE_W-1:0]   rdata_o
);
  import ulenc_pkg::*;

  logic [BYTE_W-1:0] mem_q [LINE_BYTES];
  logic [BYTE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/ulenc_ctrl.sv =====
// ----------------------------------------------------------------------------
// ulenc_ctrl
// Line sequencer: fills the store, then reads it back group by group and
// drives the output register with length, data and newline characters.
// ----------------------------------------------------------------------------
module ulenc_ctrl #(
  parameter int unsigned LINE_BYTES = ulenc_pkg::LINE_BYTES_DEF,
  parameter int unsigned AW         = $clog2(LINE_BYTES)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [ulenc_pkg::ZSYM_W-1:0]  zero_sym_i,
  ulenc_in_if.sink                      in_i,
  ulenc_out_if.source                   out_o,
  output logic                          st_we_o,
  output logic [AW-1:0]                 st_waddr_o,
  output logic [ulenc_pkg::BYTE_W-1:0]  st_wdata_o,
  output logic                          st_re_o,
  output logic [AW-1:0]                 st_raddr_o,
  input  logic [ulenc_pkg::BYTE_W-1:0]  st_rdata_i
);
  import ulenc_pkg::*;

  localparam int unsigned CNT_W = $clog2(LINE_BYTES + 1);
  localparam int unsigned IDX_W = $clog2(LINE_BYTES + 3);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LEN  = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_CAP  = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;
  localparam logic [2:0] S_NL   = 3'd5;

  logic [2:0]         state_q, state_d;
  logic [CNT_W-1:0]   fill_q, fill_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic [1:0]         sub_q, sub_d;
  logic [1:0]         sym_q, sym_d;
  logic [GROUP_W-1:0] grp_q, grp_d;
  logic               ov_q, ov_d;
  logic [BYTE_W-1:0]  oc_q, oc_d;
  logic               ol_q, ol_d;

  logic               in_fire;
  logic               slot_free;
  logic               idx_live;
  logic [CNT_W-1:0]   cnt_next;
  logic [BYTE_W-1:0]  rd_byte;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign slot_free  = !ov_q || out_o.ready;
  assign idx_live   = idx_q < IDX_W'(count_q);
  assign cnt_next   = fill_q + CNT_W'(1);
  // bytes past the end of a short last group count as zero
  assign rd_byte    = idx_live ? st_rdata_i : '0;

  always_comb begin
    state_d = state_q;
    fill_d  = fill_q;
    count_d = count_q;
    idx_d   = idx_q;
    sub_d   = sub_q;
    sym_d   = sym_q;
    grp_d   = grp_q;
    ov_d    = ov_q && !out_o.ready;
    oc_d    = oc_q;
    ol_d    = ol_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (cnt_next == CNT_W'(LINE_BYTES) || in_i.end_of_data) begin
            count_d = cnt_next;
            fill_d  = '0;
            idx_d   = '0;
            state_d = S_LEN;
          end else begin
            fill_d  = cnt_next;
          end
        end
      end
      S_LEN: begin
        if (slot_free) begin
          ov_d    = 1'b1;
          oc_d    = BYTE_W'(count_q) + CHAR_OFFSET;
          ol_d    = 1'b0;
          sub_d   = '0;
          state_d = S_RD;
        end
      end
      S_RD: begin
        state_d = S_CAP;
      end
      S_CAP: begin
        // first byte of the group ends up in the low bits
        grp_d = {rd_byte, grp_q[GROUP_W-1:BYTE_W]};
        idx_d = idx_q + IDX_W'(1);
        if (sub_q == 2'd2) begin
          sym_d   = '0;
          state_d = S_EMIT;
        end else begin
          sub_d   = sub_q + 2'd1;
          state_d = S_RD;
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          ov_d  = 1'b1;
          oc_d  = map_six(grp_q[SIX_W-1:0], zero_sym_i);
          ol_d  = 1'b0;
          grp_d = grp_q >> SIX_W;
          sym_d = sym_q + 2'd1;
          if (sym_q == 2'd3) begin
            if (idx_live) begin
              sub_d   = '0;
              state_d = S_RD;
            end else begin
              state_d = S_NL;
            end
          end
        end
      end
      S_NL: begin
        if (slot_free) begin
          ov_d    = 1'b1;
          oc_d    = NEWLINE_CHAR;
          ol_d    = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fill_q  <= '0;
      count_q <= '0;
      idx_q   <= '0;
      sub_q   <= '0;
      sym_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      count_q <= count_d;
      idx_q   <= idx_d;
      sub_q   <= sub_d;
      sym_q   <= sym_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    grp_q <= grp_d;
    oc_q  <= oc_d;
    ol_q  <= ol_d;
  end

  assign st_we_o    = in_fire;
  assign st_waddr_o = fill_q[AW-1:0];
  assign st_wdata_o = in_i.data_byte;
  assign st_re_o    = (state_q == S_RD) && idx_live;
  assign st_raddr_o = idx_q[AW-1:0];

  assign out_o.valid    = ov_q;
  assign out_o.out_char = oc_q;
  assign out_o.run_last = ol_q;

  // ---------------------------------------------------------------------------
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q < CNT_W'(LINE_BYTES))
    else $error("fill count reached line length without a flush");

  a_flush_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (in_i.end_of_data || cnt_next == CNT_W'(LINE_BYTES)) |=>
      state_q == S_LEN && fill_q == '0)
    else $error("flushing byte did not start a burst");

  a_cap_after_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CAP |-> $past(state_q) == S_RD)
    else $error("capture without a preceding read");

  a_last_is_nl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && ol_q |-> oc_q == NEWLINE_CHAR)
    else $error("burst end flag on a character other than newline");

  a_no_accept_in_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_IDLE |-> !in_fire && !st_we_o)
    else $error("store written during a burst");

endmodule

// ===== rtl/uuencode_line_encoder.sv =====
// ----------------------------------------------------------------------------
// uuencode_line_encoder
// Buffers raw bytes into lines and emits each line as length character,
// four characters per 3-byte group (low six bits first) and a newline.
// ----------------------------------------------------------------------------
//   channel   dir   handshake      payload
//   in_i      in    valid/ready    data_byte[7:0], end_of_data
//   out_o     out   valid/ready    out_char[7:0], run_last
//   cfg       in    cfg_we_i       cfg_data_i[6:0] (zero_symbol)
//
// A byte that does not close a line is written to the store and the sequencer stays idle.
// A closing byte of a line starts a burst: the length character, then per group
// three reads through the store's single read port (read state, then capture
// state) plus four character loads of the one output register, then the newline.
// Output stalls hold the sequencer; no input is taken during a burst.
// Reset clears the fill count and control state; the line store needs no clearing.
// ----------------------------------------------------------------------------
module uuencode_line_encoder #(
  parameter int unsigned LINE_BYTES = ulenc_pkg::LINE_BYTES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ulenc_pkg::ZSYM_W-1:0]  cfg_data_i,
  ulenc_in_if.sink                      in_i,
  ulenc_out_if.source                   out_o
);
  import ulenc_pkg::*;

  localparam int unsigned AW = $clog2(LINE_BYTES);

  logic [ZSYM_W-1:0] zero_sym_q;
  logic              st_we;
  logic [AW-1:0]     st_waddr;
  logic [BYTE_W-1:0] st_wdata;
  logic              st_re;
  logic [AW-1:0]     st_raddr;
  logic [BYTE_W-1:0] st_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_sym_q <= ZERO_SYM_RESET;
    end else if (cfg_we_i) begin
      zero_sym_q <= cfg_data_i;
    end
  end

  ulenc_ctrl #(
    .LINE_BYTES (LINE_BYTES),
    .AW         (AW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .zero_sym_i (zero_sym_q),
    .in_i       (in_i),
    .out_o      (out_o),
    .st_we_o    (st_we),
    .st_waddr_o (st_waddr),
    .st_wdata_o (st_wdata),
    .st_re_o    (st_re),
    .st_raddr_o (st_raddr),
    .st_rdata_i (st_rdata)
  );

  ulenc_store #(
    .LINE_BYTES (LINE_BYTES),
    .AW         (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .re_i    (st_re),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

endmodule
